// ----- design/aesbm_pkg.sv -----
`default_nettype none
package aesbm_pkg;

	localparam int ROUND_KEY_WORDS = 60;
	localparam int BLOCK_BYTES     = 16;
	localparam int RK_ROWS         = ROUND_KEY_WORDS / 4;
	localparam int RK_AW           = $clog2(RK_ROWS);

	// chaining modes
	localparam logic [2:0] MODE_ECB = 3'd0;
	localparam logic [2:0] MODE_CBC = 3'd1;
	localparam logic [2:0] MODE_CFB = 3'd2;
	localparam logic [2:0] MODE_OFB = 3'd3;
	localparam logic [2:0] MODE_CTR = 3'd4;

	// register indexes
	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_KLEN  = 3'd4;
	localparam logic [2:0] REG_MODE  = 3'd5;
	localparam logic [2:0] REG_IVUP  = 3'd6;
	localparam logic [2:0] REG_IVLO  = 3'd7;

	typedef struct packed {
		logic [63:0] plain_upper;
		logic [63:0] plain_lower;
		logic [4:0]  valid_bytes;
		logic        first_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] cipher_upper;
		logic [63:0] cipher_lower;
		logic [4:0]  out_bytes;
	} out_item_t;

	typedef struct packed {
		logic             we;
		logic [RK_AW-1:0] addr;
		logic [127:0]     data;
	} rk_wr_t;

	typedef enum logic [2:0] {
		ENG_IDLE, ENG_KEYW, ENG_LOAD, ENG_ADD0, ENG_RND, ENG_FIN
	} eng_state_t;

	typedef enum logic {
		KS_IDLE, KS_RUN
	} ks_state_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// one cipher round, byte 0 in the top bits; last round skips mixcolumns
	function automatic logic [127:0] aes_round(input logic [127:0] st,
			input logic [127:0] rk, input logic last);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) begin
			s[i] = SBOX[st[127-8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[i+4*c] = s[i + 4*((c+i) & 3)];
			end
		end
		for (int c = 0; c < 4; c++) begin
			all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
			m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
			m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
			m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
		end
		for (int i = 0; i < 16; i++) begin
			res[127-8*i -: 8] = last ? t[i] : m[i];
		end
		return res ^ rk;
	endfunction

endpackage
`default_nettype wire

// ----- design/aes_block_mode_engine.sv -----
`default_nettype none
// channel | direction | handshake         | payload
// in      | into      | in_valid/in_stall | in_item (plaintext, valid_bytes, first_block)
// out     | out of    | out_valid/out_stall | out_item (ciphertext, out_bytes)
// cfg     | into      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// the next item is taken only once the engine has moved the last result to the output
// register, one aes round per cycle from the round-key memory; an item with first_block
// first waits for key expansion
// reset clears control state and the chaining block; the round-key memory is not cleared
// a finished item waits in the output register, so the next item is taken meanwhile
module aes_block_mode_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire aesbm_pkg::in_item_t in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output aesbm_pkg::out_item_t     out_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [63:0]         cfg_data
);
	// configuration registers
	logic [255:0] key_q;
	logic [3:0]   klen_q;
	logic [2:0]   mode_cfg_q;
	logic [127:0] iv_q;

	// engine state
	aesbm_pkg::eng_state_t eng_q, eng_d;
	logic [127:0] chain_q;
	logic [127:0] plain_q;
	logic [127:0] st_q;
	logic [4:0]   n_q;
	logic [2:0]   mode_q;
	logic [3:0]   r_q;
	logic         out_valid_q;
	aesbm_pkg::out_item_t out_q;

	// round keys
	aesbm_pkg::rk_wr_t rk_wr;
	logic                      ks_busy;
	logic [3:0]                rounds;
	logic [aesbm_pkg::RK_AW-1:0] raddr;
	logic [127:0]              rk;

	logic         accept;
	logic [4:0]   n_sat;
	logic [127:0] bmask;
	logic [127:0] pmask_in;
	logic [127:0] blk_in;
	logic         fin_go;
	logic [127:0] stream;
	logic [63:0]  ctr;
	logic [63:0]  ctr_inc;
	logic [127:0] ctr_next;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (eng_q != aesbm_pkg::ENG_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			klen_q     <= 4'd4;
			mode_cfg_q <= aesbm_pkg::MODE_ECB;
			iv_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				aesbm_pkg::REG_KEY0: key_q[255:192] <= cfg_data;
				aesbm_pkg::REG_KEY1: key_q[191:128] <= cfg_data;
				aesbm_pkg::REG_KEY2: key_q[127:64]  <= cfg_data;
				aesbm_pkg::REG_KEY3: key_q[63:0]    <= cfg_data;
				aesbm_pkg::REG_KLEN: klen_q         <= cfg_data[3:0];
				aesbm_pkg::REG_MODE: mode_cfg_q     <= cfg_data[2:0];
				aesbm_pkg::REG_IVUP: iv_q[127:64]   <= cfg_data;
				aesbm_pkg::REG_IVLO: iv_q[63:0]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte count saturates at a full block; bytes beyond it are masked
	assign n_sat = (in_item.valid_bytes > 5'd16) ? 5'd16 : in_item.valid_bytes;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pmask_in[127-8*i -: 8] = (5'(i) < n_sat) ? 8'hff : 8'h00;
			bmask[127-8*i -: 8]    = (5'(i) < n_q) ? 8'hff : 8'h00;
		end
	end

	// cipher input per mode
	always_comb begin
		case (mode_q)
			aesbm_pkg::MODE_CBC: blk_in = plain_q ^ chain_q;
			aesbm_pkg::MODE_CFB,
			aesbm_pkg::MODE_OFB,
			aesbm_pkg::MODE_CTR: blk_in = chain_q;
			default:             blk_in = plain_q;
		endcase
	end

	// round key row: row 0 in load, row 1 in first add, then one ahead of the round count
	always_comb begin
		case (eng_q)
			aesbm_pkg::ENG_ADD0: raddr = aesbm_pkg::RK_AW'(1);
			aesbm_pkg::ENG_RND:  raddr = (r_q == rounds) ? '0 : aesbm_pkg::RK_AW'(r_q + 4'd1);
			default:             raddr = '0;
		endcase
	end

	// ctr field: bytes 8..15 little endian
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			ctr[8*b +: 8] = chain_q[63-8*b -: 8];
		end
		ctr_inc = ctr + 64'd1;
		ctr_next[127:64] = chain_q[127:64];
		for (int b = 0; b < 8; b++) begin
			ctr_next[63-8*b -: 8] = ctr_inc[8*b +: 8];
		end
	end

	assign stream = (plain_q ^ st_q) & bmask;
	assign fin_go = (eng_q == aesbm_pkg::ENG_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		eng_d = eng_q;
		case (eng_q)
			aesbm_pkg::ENG_IDLE:
				if (accept) eng_d = in_item.first_block ? aesbm_pkg::ENG_KEYW
				                                        : aesbm_pkg::ENG_LOAD;
			aesbm_pkg::ENG_KEYW: if (!ks_busy) eng_d = aesbm_pkg::ENG_LOAD;
			aesbm_pkg::ENG_LOAD: eng_d = aesbm_pkg::ENG_ADD0;
			aesbm_pkg::ENG_ADD0: eng_d = aesbm_pkg::ENG_RND;
			aesbm_pkg::ENG_RND:  if (r_q == rounds) eng_d = aesbm_pkg::ENG_FIN;
			aesbm_pkg::ENG_FIN:  if (fin_go) eng_d = aesbm_pkg::ENG_IDLE;
			default:             eng_d = aesbm_pkg::ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q       <= aesbm_pkg::ENG_IDLE;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			eng_q <= eng_d;
			if (accept && in_item.first_block) begin
				chain_q <= iv_q;
			end else if (fin_go) begin
				case (mode_q)
					aesbm_pkg::MODE_CBC: chain_q <= st_q;
					aesbm_pkg::MODE_CFB: chain_q <= stream;
					aesbm_pkg::MODE_OFB: chain_q <= st_q;
					aesbm_pkg::MODE_CTR: chain_q <= ctr_next;
					default:             chain_q <= chain_q;
				endcase
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plain_q <= {in_item.plain_upper, in_item.plain_lower} & pmask_in;
			n_q     <= n_sat;
			mode_q  <= mode_cfg_q;
		end
		case (eng_q)
			aesbm_pkg::ENG_LOAD: st_q <= blk_in;
			aesbm_pkg::ENG_ADD0: begin
				st_q <= st_q ^ rk;
				r_q  <= 4'd1;
			end
			aesbm_pkg::ENG_RND: begin
				st_q <= aesbm_pkg::aes_round(st_q, rk, r_q == rounds);
				r_q  <= r_q + 4'd1;
			end
			default: ;
		endcase
		if (fin_go) begin
			case (mode_q)
				aesbm_pkg::MODE_CFB,
				aesbm_pkg::MODE_OFB,
				aesbm_pkg::MODE_CTR: begin
					{out_q.cipher_upper, out_q.cipher_lower} <= stream;
					out_q.out_bytes <= n_q;
				end
				default: begin
					{out_q.cipher_upper, out_q.cipher_lower} <= st_q;
					out_q.out_bytes <= 5'd16;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	aesbm_key_sched u_key_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && in_item.first_block),
		.key     (key_q),
		.key_len (klen_q),
		.busy    (ks_busy),
		.rounds  (rounds),
		.rk_wr   (rk_wr)
	);

	aesbm_ram #(
		.WIDTH (128),
		.DEPTH (aesbm_pkg::RK_ROWS)
	) u_rk_ram (
		.clk   (clk),
		.we    (rk_wr.we),
		.waddr (rk_wr.addr),
		.wdata (rk_wr.data),
		.raddr (raddr),
		.rdata (rk)
	);

	// rounds only run once expansion has finished
	a_no_read_during_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q == aesbm_pkg::ENG_RND || eng_q == aesbm_pkg::ENG_ADD0) |-> !ks_busy)
		else $error("round key read while expanding");

	a_round_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rounds == 4'd10 || rounds == 4'd12 || rounds == 4'd14))
		else $error("bad round count");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (eng_q == aesbm_pkg::ENG_KEYW || eng_q == aesbm_pkg::ENG_LOAD))
		else $error("accepted item not started");

	a_out_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_bytes <= 5'd16)
		else $error("out_bytes above a block");
endmodule
`default_nettype wire

// ----- design/aesbm_ram.sv -----
`default_nettype none
module aesbm_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- design/aesbm_key_sched.sv -----
`default_nettype none
module aesbm_key_sched (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [255:0]  key,
	input  wire logic [3:0]    key_len,
	output logic               busy,
	output logic [3:0]         rounds,
	output aesbm_pkg::rk_wr_t  rk_wr
);
	aesbm_pkg::ks_state_t ks_q, ks_d;
	logic [5:0]  i_q;
	logic [5:0]  last_q;
	logic [3:0]  nk_q;
	logic [2:0]  m_q;
	logic [7:0]  rc_q;
	logic [3:0]  rounds_q;
	logic [31:0] win_q [8];
	logic [255:0] key_q;
	logic [3:0]  nk_new;
	logic [31:0] t;
	logic [31:0] back;
	logic [31:0] word;

	always_comb begin
		case (key_len)
			4'd6:    nk_new = 4'd6;
			4'd8:    nk_new = 4'd8;
			default: nk_new = 4'd4;
		endcase
	end

	// word i-nk from the sliding window
	always_comb begin
		case (nk_q)
			4'd6:    back = win_q[5];
			4'd8:    back = win_q[7];
			default: back = win_q[3];
		endcase
		t = win_q[0];
		if (m_q == 3'd0) begin
			t = aesbm_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'd0};
		end else if (nk_q == 4'd8 && m_q == 3'd4) begin
			t = aesbm_pkg::sub_word(win_q[0]);
		end
		if ({2'd0, i_q} < {4'd0, nk_q}) begin
			word = key_q[255 - 32*i_q[2:0] -: 32];
		end else begin
			word = back ^ t;
		end
	end

	always_comb begin
		ks_d = ks_q;
		case (ks_q)
			aesbm_pkg::KS_IDLE: if (start) ks_d = aesbm_pkg::KS_RUN;
			aesbm_pkg::KS_RUN:  if (i_q == last_q) ks_d = aesbm_pkg::KS_IDLE;
			default:            ks_d = aesbm_pkg::KS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q     <= aesbm_pkg::KS_IDLE;
			rounds_q <= 4'd10;
		end else begin
			ks_q <= ks_d;
			if (ks_q == aesbm_pkg::KS_IDLE && start) begin
				rounds_q <= nk_new + 4'd6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ks_q == aesbm_pkg::KS_IDLE && start) begin
			key_q  <= key;
			nk_q   <= nk_new;
			last_q <= 6'(4 * (nk_new + 4'd7) - 1);
			i_q    <= '0;
			m_q    <= '0;
			rc_q   <= 8'h01;
		end else if (ks_q == aesbm_pkg::KS_RUN) begin
			i_q <= i_q + 6'd1;
			m_q <= ({1'b0, m_q} == nk_q - 4'd1) ? 3'd0 : m_q + 3'd1;
			if (m_q == 3'd0 && {2'd0, i_q} >= {4'd0, nk_q}) begin
				rc_q <= aesbm_pkg::xtime(rc_q);
			end
			win_q[0] <= word;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	assign busy          = (ks_q == aesbm_pkg::KS_RUN);
	assign rounds        = rounds_q;
	assign rk_wr.we      = busy && (i_q[1:0] == 2'd3);
	assign rk_wr.addr    = i_q[aesbm_pkg::RK_AW+1:2];
	assign rk_wr.data    = {win_q[2], win_q[1], win_q[0], word};
endmodule
`default_nettype wire
